[sv/nbcf_pkg.sv]
// Shared types, register codes and helpers for the cutoff force update block.
package nbcf_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_TIME_STEP = 2'd0;
    localparam logic [1:0] CFG_CUTOFF    = 2'd1;
    localparam logic [1:0] CFG_HOME      = 2'd2;

    localparam logic [31:0] TIME_STEP_RST = 32'd655;
    localparam logic [31:0] CUTOFF_RST    = 32'd1638400;
    localparam logic [2:0]  HOME_RST      = 3'd0;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SOURCE = 1'b1;

    localparam logic [63:0] MAX63     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAX63 = 64'h8000_0000_0000_0001;
    localparam logic [32:0] DV_CAP    = 33'h1_0000_0000;

    // square root starts at 4^23, enough for any radicand below 2^48
    localparam logic [4:0] SQRT_START = 5'd23;
    // countdown start for the restoring divider, which produces 63 quotient bits
    localparam logic [5:0] QUOT_LAST  = 6'd62;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic        func;
        logic [31:0] mass;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic        is_self;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [31:0] new_pos_x;
        logic [31:0] new_pos_y;
        logic [31:0] new_pos_z;
        logic [31:0] new_vel_x;
        logic [31:0] new_vel_y;
        logic [31:0] new_vel_z;
        logic [2:0]  octant;
        logic        leaves_home;
    } t_out;

    typedef struct packed {
        logic [31:0] time_step;
        logic [31:0] cutoff_squared;
        logic [2:0]  home_octant;
    } t_cfg;

    // classified work for the back end
    typedef struct packed {
        logic             load;
        logic             add;
        logic             emit;
        logic [31:0]      mass;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
    } t_cmd;

    function automatic logic [31:0] sat32(input logic signed [49:0] v);
        logic [31:0] res;
        if (v > $signed({18'h0, 32'h7FFF_FFFF})) begin
            res = 32'h7FFF_FFFF;
        end else if (v < $signed({18'h3FFFF, 32'h8000_0000})) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

[sv/nbcf_front.sv]
// Front end: accepts items, tracks the loaded target and classifies work.
module nbcf_front import nbcf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    input  logic i_q_full,
    output logic o_push,
    output t_cmd o_cmd
);

    logic r_tvalid;
    logic n_tvalid;
    logic w_acc;
    logic w_valid_after;

    assign o_in_ready    = !i_q_full;
    assign w_acc         = i_in_valid && o_in_ready;
    assign w_valid_after = (i_in_data.func == FUNC_LOAD) || r_tvalid;

    always_comb begin
        o_cmd.load = (i_in_data.func == FUNC_LOAD);
        o_cmd.add  = (i_in_data.func == FUNC_SOURCE) && r_tvalid && !i_in_data.is_self;
        o_cmd.emit = i_in_data.last && w_valid_after;
        o_cmd.mass = i_in_data.mass;
        o_cmd.pos  = {i_in_data.pos_z, i_in_data.pos_y, i_in_data.pos_x};
        o_cmd.vel  = {i_in_data.vel_z, i_in_data.vel_y, i_in_data.vel_x};
    end

    // transactions with nothing to do are dropped here
    assign o_push   = w_acc && (o_cmd.load || o_cmd.add || o_cmd.emit);
    assign n_tvalid = w_acc ? (w_valid_after && !i_in_data.last) : r_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else begin
            r_tvalid <= n_tvalid;
        end
    end

endmodule

[sv/nbcf_queue.sv]
// Two-entry command queue between front and back end.
module nbcf_queue import nbcf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_cmd o_cmd
);

    localparam int PW = $clog2(Q_DEPTH);

    t_cmd                r_mem [Q_DEPTH];
    logic [PW-1:0]       r_wp;
    logic [PW-1:0]       r_rp;
    logic [PW:0]         r_cnt;
    logic [PW-1:0]       n_wp;
    logic [PW-1:0]       n_rp;
    logic [PW:0]         n_cnt;

    assign o_full  = (r_cnt == (PW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

[sv/nbcf_back.sv]
// Back end: force accumulation and kick/drift sequencer with shared mul, sqrt, divider.
module nbcf_back import nbcf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_q_empty,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DIFF   = 5'd1;
    localparam logic [4:0] S_SQ     = 5'd2;
    localparam logic [4:0] S_SQACC  = 5'd3;
    localparam logic [4:0] S_R2CHK  = 5'd4;
    localparam logic [4:0] S_SQRT   = 5'd5;
    localparam logic [4:0] S_MM     = 5'd6;
    localparam logic [4:0] S_MMW    = 5'd7;
    localparam logic [4:0] S_R3W    = 5'd8;
    localparam logic [4:0] S_AX     = 5'd9;
    localparam logic [4:0] S_AXM1   = 5'd10;
    localparam logic [4:0] S_AXM2   = 5'd11;
    localparam logic [4:0] S_DIV    = 5'd12;
    localparam logic [4:0] S_ADD    = 5'd13;
    localparam logic [4:0] S_EAX    = 5'd14;
    localparam logic [4:0] S_EM1    = 5'd15;
    localparam logic [4:0] S_EM2    = 5'd16;
    localparam logic [4:0] S_EDV    = 5'd17;
    localparam logic [4:0] S_EDXM   = 5'd18;
    localparam logic [4:0] S_EDX    = 5'd19;
    localparam logic [4:0] S_OUT    = 5'd20;

    logic [4:0]         r_state;
    logic [4:0]         n_state;

    // target body
    logic [31:0]        r_tmass;
    logic signed [31:0] r_tpos [3];
    logic signed [31:0] r_tvel [3];
    logic signed [63:0] r_acc [3];

    // source work
    logic [31:0]        r_smass;
    logic [31:0]        r_spos [3];
    logic [31:0]        r_ad [3];
    logic               r_dneg [3];
    logic [1:0]         r_k;
    logic               r_emit;
    logic [49:0]        r_r2;
    logic [63:0]        r_mm;
    logic [55:0]        r_r3;
    logic [47:0]        r_sn;
    logic [48:0]        r_sr;
    logic [4:0]         r_sj;

    // shared multiplier and divider
    logic [63:0]        r_prod;
    logic [63:0]        r_part;
    logic [58:0]        r_rem;
    logic [62:0]        r_nlo;
    logic [62:0]        r_q;
    logic [58:0]        r_den;
    logic [5:0]         r_dcnt;
    logic               r_for_emit;
    logic [62:0]        r_mag;

    logic signed [31:0] r_nv [3];
    logic signed [31:0] r_np [3];
    logic               r_oval;
    t_out               r_out;

    logic [31:0]        w_ma;
    logic [31:0]        w_mb;
    logic [47:0]        w_lim;
    logic [62:0]        w_fm;
    logic [31:0]        w_nvmag;
    logic [95:0]        w_n96;
    logic [59:0]        w_rem_sh;
    logic               w_rem_ge;
    logic [48:0]        w_bit;
    logic [48:0]        w_st;
    logic               w_last_ax;
    logic [4:0]         w_after_src;
    logic [32:0]        w_dvm;
    logic [49:0]        w_dv50;
    logic [49:0]        w_nv50;
    logic [49:0]        w_px50;
    logic [49:0]        w_np50;
    logic [64:0]        w_term;
    logic signed [64:0] w_sum;
    logic [63:0]        w_acc_new;
    logic [2:0]         w_oct;
    logic               w_out_free;

    assign w_lim       = {i_cfg.cutoff_squared, 16'h0};
    assign w_fm        = r_acc[r_k][63] ? 63'(-r_acc[r_k]) : r_acc[r_k][62:0];
    assign w_nvmag     = r_nv[r_k][31] ? 32'(-{r_nv[r_k][31], r_nv[r_k]}) : r_nv[r_k];
    assign w_n96       = 96'(r_part) + {r_prod, 32'h0};
    assign w_rem_sh    = {r_rem, r_nlo[62]};
    assign w_rem_ge    = (w_rem_sh >= {1'b0, r_den});
    assign w_bit       = 49'(1) << {r_sj, 1'b0};
    assign w_st        = r_sr + w_bit;
    assign w_last_ax   = (r_k == 2'd2);
    assign w_after_src = r_emit ? S_EAX : S_IDLE;
    assign w_out_free  = !r_oval || i_out_ready;
    assign o_pop       = (r_state == S_IDLE) && !i_q_empty;

    // kick: v' = sat(v + dv), dv capped at 2^32
    assign w_dvm  = (r_mag > 63'(DV_CAP)) ? DV_CAP : r_mag[32:0];
    assign w_dv50 = r_acc[r_k][63] ? -{17'h0, w_dvm} : {17'h0, w_dvm};
    assign w_nv50 = {{18{r_tvel[r_k][31]}}, r_tvel[r_k]} + w_dv50;
    // drift: x' = sat(x + |v'|*dt/2^16 with sign of v')
    assign w_px50 = r_nv[r_k][31] ? -{2'b0, r_prod[63:16]} : {2'b0, r_prod[63:16]};
    assign w_np50 = {{18{r_tpos[r_k][31]}}, r_tpos[r_k]} + w_px50;

    // saturating accumulate, clamp symmetric at +-(2^63-1)
    assign w_term = r_dneg[r_k] ? -{2'b0, r_mag} : {2'b0, r_mag};
    assign w_sum  = $signed({r_acc[r_k][63], r_acc[r_k]}) + $signed(w_term);
    always_comb begin
        if (w_sum > $signed({1'b0, MAX63})) begin
            w_acc_new = MAX63;
        end else if (w_sum < $signed({1'b1, NEG_MAX63})) begin
            w_acc_new = NEG_MAX63;
        end else begin
            w_acc_new = w_sum[63:0];
        end
    end

    always_comb begin
        w_oct[0] = !r_np[0][31] && (r_np[0] != 32'sd0);
        w_oct[1] = !r_np[1][31] && (r_np[1] != 32'sd0);
        w_oct[2] = !r_np[2][31] && (r_np[2] != 32'sd0);
    end

    always_comb begin
        unique case (r_state)
            S_SQ: begin
                w_ma = r_ad[r_k];
                w_mb = r_ad[r_k];
            end
            S_MM: begin
                w_ma = r_tmass;
                w_mb = r_smass;
            end
            S_MMW: begin
                w_ma = r_r2[47:16];
                w_mb = {8'h0, r_sr[23:0]};
            end
            S_AX: begin
                w_ma = r_mm[31:0];
                w_mb = r_ad[r_k];
            end
            S_AXM1: begin
                w_ma = r_mm[63:32];
                w_mb = r_ad[r_k];
            end
            S_EAX: begin
                w_ma = w_fm[31:0];
                w_mb = i_cfg.time_step;
            end
            S_EM1: begin
                w_ma = {1'b0, w_fm[62:32]};
                w_mb = i_cfg.time_step;
            end
            S_EDXM: begin
                w_ma = w_nvmag;
                w_mb = i_cfg.time_step;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    if (i_cmd.load) begin
                        n_state = i_cmd.emit ? S_EAX : S_IDLE;
                    end else if (i_cmd.add) begin
                        n_state = S_DIFF;
                    end else begin
                        n_state = S_EAX;
                    end
                end
            end
            S_DIFF:  n_state = S_SQ;
            S_SQ:    n_state = S_SQACC;
            S_SQACC: begin
                if (r_prod > 64'(w_lim)) begin
                    n_state = w_after_src;
                end else if (w_last_ax) begin
                    n_state = S_R2CHK;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_R2CHK: n_state = (r_r2 > 50'(w_lim)) ? w_after_src : S_SQRT;
            S_SQRT:  n_state = (r_sj == 5'd0) ? S_MM : S_SQRT;
            S_MM:    n_state = S_MMW;
            S_MMW:   n_state = S_R3W;
            S_R3W:   n_state = S_AX;
            S_AX: begin
                if (r_mm == 64'h0 || r_ad[r_k] == 32'h0) begin
                    n_state = w_last_ax ? w_after_src : S_AX;
                end else if (r_r3 == 56'h0) begin
                    n_state = S_ADD;
                end else begin
                    n_state = S_AXM1;
                end
            end
            S_AXM1:  n_state = S_AXM2;
            S_AXM2:  n_state = ({7'h0, w_n96[95:47]} >= r_r3) ? S_ADD : S_DIV;
            S_DIV: begin
                if (r_dcnt == 6'd0) begin
                    n_state = r_for_emit ? S_EDV : S_ADD;
                end
            end
            S_ADD:   n_state = w_last_ax ? w_after_src : S_AX;
            S_EAX: begin
                if (w_fm == 63'h0 || r_tmass == 32'h0) begin
                    n_state = S_EDV;
                end else begin
                    n_state = S_EM1;
                end
            end
            S_EM1:   n_state = S_EM2;
            S_EM2: begin
                n_state = (r_tmass[31:16] == 16'h0) &&
                          (w_n96[95:63] >= {r_tmass[15:0], 17'h0})
                          ? S_EDV : S_DIV;
            end
            S_EDV:   n_state = S_EDXM;
            S_EDXM:  n_state = S_EDX;
            S_EDX:   n_state = w_last_ax ? S_OUT : S_EAX;
            S_OUT:   n_state = w_out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && w_out_free) begin
                r_oval <= 1'b1;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(w_ma) * 64'(w_mb);
        unique case (r_state)
            S_IDLE: begin
                r_k <= 2'd0;
                if (!i_q_empty) begin
                    r_emit <= i_cmd.emit;
                    if (i_cmd.load) begin
                        r_tmass <= i_cmd.mass;
                        for (int i = 0; i < 3; i++) begin
                            r_tpos[i] <= i_cmd.pos[i];
                            r_tvel[i] <= i_cmd.vel[i];
                            r_acc[i]  <= 64'sd0;
                        end
                    end else begin
                        r_smass <= i_cmd.mass;
                        for (int i = 0; i < 3; i++) begin
                            r_spos[i] <= i_cmd.pos[i];
                        end
                    end
                end
            end
            S_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    logic [32:0] d;
                    d = {r_spos[i][31], r_spos[i]} - {r_tpos[i][31], r_tpos[i]};
                    r_dneg[i] <= d[32];
                    r_ad[i]   <= d[32] ? 32'(-d) : d[31:0];
                end
                r_r2 <= '0;
            end
            S_SQACC: begin
                r_r2 <= r_r2 + 50'(r_prod);
                r_k  <= (w_last_ax || r_prod > 64'(w_lim)) ? 2'd0 : r_k + 2'd1;
            end
            S_R2CHK: begin
                r_sn <= r_r2[47:0];
                r_sr <= '0;
                r_sj <= SQRT_START;
            end
            S_SQRT: begin
                if ({1'b0, r_sn} >= w_st) begin
                    r_sn <= r_sn - w_st[47:0];
                    r_sr <= (r_sr >> 1) + w_bit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sj <= r_sj - 5'd1;
            end
            S_MMW: r_mm <= r_prod;
            S_R3W: begin
                r_r3 <= r_prod[55:0];
                r_k  <= 2'd0;
            end
            S_AX: begin
                r_mag <= MAX63[62:0];
                if (r_mm == 64'h0 || r_ad[r_k] == 32'h0) begin
                    r_k <= w_last_ax ? 2'd0 : r_k + 2'd1;
                end
            end
            S_AXM1: r_part <= r_prod;
            S_AXM2: begin
                // numerator is mm*|d|*2^16; top part compared first for saturation
                r_rem      <= 59'(w_n96[95:47]);
                r_nlo      <= {w_n96[46:0], 16'h0};
                r_den      <= 59'(r_r3);
                r_q        <= '0;
                r_dcnt     <= QUOT_LAST;
                r_for_emit <= 1'b0;
                r_mag      <= MAX63[62:0];
            end
            S_DIV: begin
                r_rem  <= w_rem_ge ? 59'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[58:0];
                r_nlo  <= {r_nlo[61:0], 1'b0};
                r_q    <= {r_q[61:0], w_rem_ge};
                r_dcnt <= r_dcnt - 6'd1;
                if (r_dcnt == 6'd0) begin
                    r_mag <= {r_q[61:0], w_rem_ge};
                end
            end
            S_ADD: begin
                r_acc[r_k] <= w_acc_new;
                r_k        <= w_last_ax ? 2'd0 : r_k + 2'd1;
            end
            S_EAX: begin
                if (w_fm == 63'h0) begin
                    r_mag <= '0;
                end else begin
                    r_mag <= 63'(DV_CAP);
                end
            end
            S_EM1: r_part <= r_prod;
            S_EM2: begin
                r_rem      <= 59'(w_n96[95:63]);
                r_nlo      <= w_n96[62:0];
                r_den      <= {10'h0, r_tmass, 17'h0};
                r_q        <= '0;
                r_dcnt     <= QUOT_LAST;
                r_for_emit <= 1'b1;
            end
            S_EDV: r_nv[r_k] <= sat32($signed(w_nv50));
            S_EDX: begin
                r_np[r_k] <= sat32($signed(w_np50));
                r_k       <= w_last_ax ? 2'd0 : r_k + 2'd1;
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out.new_pos_x   <= r_np[0];
                    r_out.new_pos_y   <= r_np[1];
                    r_out.new_pos_z   <= r_np[2];
                    r_out.new_vel_x   <= r_nv[0];
                    r_out.new_vel_y   <= r_nv[1];
                    r_out.new_vel_z   <= r_nv[2];
                    r_out.octant      <= w_oct;
                    r_out.leaves_home <= (w_oct != i_cfg.home_octant);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;

endmodule

[sv/nbody_cutoff_force_update.sv]
// Top level: config registers, front end, command queue and back end.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out)
//  cfg     | input     | i_cfg_we, i_cfg_index      | i_cfg_data (32 bit)
//
// A target load is taken straight from idle. A source runs difference, squares, cutoff check
// and square root, then a term per axis through the divider unless it saturates early, the
// distance is zero or it is skipped; the pace is set by the 1-bit-per-cycle divider, the 24-step
// square root and the one 32x32 multiplier. Final emit: per axis kick and drift, then output load.
// Reset is synchronous, active low, and clears control state only; no clearing pass.
// The two-entry queue lets the front keep accepting while the back is busy; a result held
// in the output register stalls only the next emit.
module nbody_cutoff_force_update import nbcf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_time_step;
    logic [31:0] r_cutoff;
    logic [2:0]  r_home;
    t_cfg        w_cfg;
    logic        w_push;
    logic        w_pop;
    logic        w_full;
    logic        w_empty;
    t_cmd        w_cmd_in;
    t_cmd        w_cmd_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RST;
            r_cutoff    <= CUTOFF_RST;
            r_home      <= HOME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TIME_STEP: r_time_step <= i_cfg_data;
                CFG_CUTOFF:    r_cutoff    <= i_cfg_data;
                CFG_HOME:      r_home      <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    assign w_cfg = '{time_step: r_time_step, cutoff_squared: r_cutoff, home_octant: r_home};

    nbcf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    nbcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .o_empty (w_empty),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out)
    );

    nbcf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_empty   (w_empty),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("command pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_empty |-> !w_pop)
        else $error("command popped from empty queue");

    a_leave_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.leaves_home == (o_out_data.octant != r_home)))
        else $error("leave flag disagrees with home octant");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule
